FILE: src/pidsc_pkg.sv
package pidsc_pkg;

  localparam int SpeedW   = 16;
  localparam int GainW    = 16;
  localparam int LimitW   = 31;
  localparam int ErrW     = SpeedW + 1;
  localparam int DiffW    = ErrW + 1;
  localparam int SumW     = 32;
  localparam int ProdW    = GainW + SumW;
  localparam int AccW     = ProdW + 2;
  localparam int DriveW   = 16;
  localparam int QuoW     = 15;
  localparam int DivSteps = QuoW;
  localparam int DivCntW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int QDepth   = 2;
  localparam int QPtrW    = 1;
  localparam int QCntW    = 2;

  localparam logic signed [SpeedW-1:0] DeadbandHi = 16'sd5;
  localparam logic signed [SpeedW-1:0] DeadbandLo = -16'sd5;
  localparam logic [LimitW-1:0]        LimitReset = 31'd1000;
  localparam logic signed [SumW-1:0]   SumMax     = 32'sh7fff_ffff;
  localparam logic signed [SumW-1:0]   SumMin     = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_DERIV_GAIN   = 2'd2,
    REG_OUTPUT_LIMIT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic [LimitW-1:0]       output_limit;
  } cfg_t;

  typedef struct packed {
    logic                   deadband;
    logic signed [ErrW-1:0] err;
  } item_t;

endpackage

FILE: src/pidsc_in_if.sv
interface pidsc_in_if;
  import pidsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] target_speed;
  logic signed [SpeedW-1:0] measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);

endinterface

FILE: src/pidsc_out_if.sv
interface pidsc_out_if;
  import pidsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive;
  logic                     saturated;
  logic                     in_deadband;

  modport source (output valid, output drive, output saturated, output in_deadband,
                  input ready);
  modport sink   (input valid, input drive, input saturated, input in_deadband,
                  output ready);

endinterface

FILE: src/pidsc_front.sv
module pidsc_front (
  pidsc_in_if.sink         in_if,
  input  logic             q_full_i,
  output logic             push_o,
  output pidsc_pkg::item_t item_o
);
  import pidsc_pkg::*;

  assign in_if.ready = !q_full_i;
  assign push_o      = in_if.valid && in_if.ready;

  // deadband test on the target and error formed at full width
  assign item_o.deadband = (in_if.target_speed <= DeadbandHi) &&
                           (in_if.target_speed >= DeadbandLo);
  assign item_o.err      = ErrW'(in_if.target_speed) - ErrW'(in_if.measured_speed);

endmodule

FILE: src/pidsc_queue.sv
module pidsc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pidsc_pkg::item_t item_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output pidsc_pkg::item_t item_o
);
  import pidsc_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: src/pidsc_back.sv
module pidsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pidsc_pkg::cfg_t  cfg_i,
  input  logic             q_valid_i,
  input  pidsc_pkg::item_t q_item_i,
  output logic             pop_o,
  pidsc_out_if.source      out_if
);
  import pidsc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_INTEG = 9'b0_0000_0010,
    S_MUL_P = 9'b0_0000_0100,
    S_MUL_I = 9'b0_0000_1000,
    S_MUL_D = 9'b0_0001_0000,
    S_ACC   = 9'b0_0010_0000,
    S_CLAMP = 9'b0_0100_0000,
    S_DIV   = 9'b0_1000_0000,
    S_DONE  = 9'b1_0000_0000
  } state_e;

  state_e                    state_q, state_d;
  logic signed [ErrW-1:0]    err_q, err_d;
  logic signed [ErrW-1:0]    prev_q, prev_d;
  logic signed [DiffW-1:0]   dif_q, dif_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic [SumW-1:0]           rem_q, rem_d;
  logic [QuoW-1:0]           quo_q, quo_d;
  logic [DivCntW-1:0]        cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic                      sat_q, sat_d;
  logic                      db_q, db_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DriveW-1:0]  out_drive_q, out_drive_d;
  logic                      out_sat_q, out_sat_d;
  logic                      out_db_q, out_db_d;

  logic signed [GainW-1:0]   mul_a;
  logic signed [SumW-1:0]    mul_b;
  logic signed [SumW:0]      sum_raw;
  logic [LimitW-1:0]         lim;
  logic signed [AccW-1:0]    lim_s;
  logic signed [AccW-1:0]    acc_abs;
  logic [SumW-1:0]           div_t;
  logic                      div_bit;
  logic signed [DriveW-1:0]  quo_s;
  logic                      out_free;

  assign lim      = (cfg_i.output_limit == '0) ? LimitW'(1) : cfg_i.output_limit;
  assign lim_s    = AccW'(lim);
  assign acc_abs  = acc_q[AccW-1] ? -acc_q : acc_q;
  assign sum_raw  = (SumW+1)'(sum_q) + (SumW+1)'(err_q);
  assign div_t    = (cnt_q == DivCntW'(DivSteps - 1)) ? rem_q : {rem_q[SumW-2:0], 1'b0};
  assign div_bit  = (div_t >= SumW'(lim));
  assign quo_s    = DriveW'(quo_d);
  assign out_free = !out_valid_q || out_if.ready;
  assign pop_o    = (state_q == S_IDLE) && q_valid_i;

  // one shared multiplier, operands stepped by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL_P: begin
        mul_a = cfg_i.prop_gain;
        mul_b = SumW'(err_q);
      end
      S_MUL_I: begin
        mul_a = cfg_i.integ_gain;
        mul_b = sum_q;
      end
      S_MUL_D: begin
        mul_a = cfg_i.deriv_gain;
        mul_b = SumW'(dif_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    prev_d      = prev_q;
    dif_d       = dif_q;
    sum_d       = sum_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    db_d        = db_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_drive_d = out_drive_q;
    out_sat_d   = out_sat_q;
    out_db_d    = out_db_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.deadband) begin
            sum_d   = '0;
            prev_d  = '0;
            quo_d   = '0;
            neg_d   = 1'b0;
            sat_d   = 1'b0;
            db_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            err_d   = q_item_i.err;
            db_d    = 1'b0;
            state_d = S_INTEG;
          end
        end
      end
      S_INTEG: begin
        // saturating integral
        if (sum_raw > (SumW+1)'(SumMax)) begin
          sum_d = SumMax;
        end else if (sum_raw < (SumW+1)'(SumMin)) begin
          sum_d = SumMin;
        end else begin
          sum_d = SumW'(sum_raw);
        end
        dif_d   = DiffW'(err_q) - DiffW'(prev_q);
        prev_d  = err_q;
        acc_d   = '0;
        state_d = S_MUL_P;
      end
      S_MUL_P: begin
        state_d = S_MUL_I;
      end
      S_MUL_I: begin
        acc_d   = acc_q + AccW'(prod_q);
        state_d = S_MUL_D;
      end
      S_MUL_D: begin
        acc_d   = acc_q + AccW'(prod_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d   = acc_q + AccW'(prod_q);
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        priority if (acc_q > lim_s) begin
          rem_d = SumW'(lim);
          neg_d = 1'b0;
          sat_d = 1'b1;
        end else if (acc_q < -lim_s) begin
          rem_d = SumW'(lim);
          neg_d = 1'b1;
          sat_d = 1'b1;
        end else begin
          rem_d = SumW'(acc_abs[LimitW-1:0]);
          neg_d = acc_q[AccW-1];
          sat_d = 1'b0;
        end
        quo_d   = '0;
        cnt_d   = DivCntW'(DivSteps - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_d = div_bit ? div_t - SumW'(lim) : div_t;
        quo_d = {quo_q[QuoW-2:0], div_bit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_drive_d = neg_q ? -quo_s : quo_s;
          out_sat_d   = sat_q;
          out_db_d    = db_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    dif_q       <= dif_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    neg_q       <= neg_d;
    sat_q       <= sat_d;
    db_q        <= db_d;
    out_drive_q <= out_drive_d;
    out_sat_q   <= out_sat_d;
    out_db_q    <= out_db_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.drive       = out_drive_q;
  assign out_if.saturated   = out_sat_q;
  assign out_if.in_deadband = out_db_q;

endmodule

FILE: src/pid_speed_controller.sv
// the back end takes one sample at a time from a two-entry queue and pops the next
//   only when idle; its rate is set by the shared multiplier sequence and the
//   15-step restoring divider, both skipped for a sample inside the deadband,
//   and a finished result waits while the result side is not ready
// reset: gains clear to zero, output limit to 1000, integral and last error to zero
module pid_speed_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pidsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pidsc_pkg::LimitW-1:0]    cfg_data_i,
  pidsc_in_if.sink                        in_i,
  pidsc_out_if.source                     out_o
);
  import pidsc_pkg::*;

  cfg_t  cfg_q;
  item_t push_item;
  item_t q_item;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= '0;
      cfg_q.integ_gain   <= '0;
      cfg_q.deriv_gain   <= '0;
      cfg_q.output_limit <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i[GainW-1:0];
        REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i[GainW-1:0];
        REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data_i[GainW-1:0];
        REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pidsc_front u_front (
    .in_if    (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  pidsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  pidsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .out_if    (out_o)
  );

  a_deadband_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.in_deadband |-> (out_o.drive == '0) && !out_o.saturated)
    else $error("deadband result with non-zero drive or saturation");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.drive <= 16'sd16384) && (out_o.drive >= -16'sd16384))
    else $error("drive outside full scale");

  a_sat_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.drive == 16'sd16384) || (out_o.drive == -16'sd16384))
    else $error("saturated result not at full scale");

endmodule
